>>> design/firq29_pkg.sv
// Shared types and constants of the Q2.29 direct-form FIR filter.
`default_nettype none

package firq29_pkg;

  localparam int DATA_W     = 32;
  localparam int ACC_W      = 64;
  localparam int OUT_SHIFT  = 31;
  localparam int TAP_CFG_W  = 10;
  localparam int COEF_IDX_W = 9;

  localparam logic ACTION_SAMPLE = 1'b0;
  localparam logic ACTION_LOAD   = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_DONE
  } firq29_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept_sample;
    logic accept_load;
    logic issue;
    logic finish;
  } firq29_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic last_tap;
    logic pipe_busy;
    logic out_free;
  } firq29_sts_t;

endpackage

`default_nettype wire

>>> design/fir_filter_q29_fixed.sv
// Top level of the direct-form FIR filter on Q2.29 samples and coefficients.
// A request with action set writes one Q2.29 coefficient at coef_index; an index at or
// beyond MAX_TAPS is dropped. A sample request enters the circular history and yields
// one Q4.27 result, bits 62..31 of a wrapping 64-bit sum of coefficient-times-sample
// products over the configured taps. A sample occupies the block while one
// multiply-accumulate walks the taps, reading one coefficient and one history word per
// cycle from two single-port-read memories, then while the read and multiply stages
// drain and the result is handed into the output register, and longer while the
// previous result still waits in the output register. The history needs no clearing
// pass after reset: a fill count makes not-yet-written slots read as zero.
// Coefficients must be loaded before they are used. tap_count may be written only while
// the block is idle; zero behaves as one tap and values above MAX_TAPS as MAX_TAPS.
`default_nettype none

module fir_filter_q29_fixed
  import firq29_pkg::*;
#(
  parameter int MAX_TAPS = 512
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire logic                     in_action,
  input  wire logic [COEF_IDX_W-1:0]    in_coef_index,
  input  wire logic signed [DATA_W-1:0] in_data_value,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output logic signed [DATA_W-1:0]      out_filtered_sample,
  input  wire logic                     cfg_valid,
  output logic                          cfg_ready,
  input  wire logic [TAP_CFG_W-1:0]     cfg_tap_count
);

  firq29_cmd_t cmd;
  firq29_sts_t sts;

  assign cfg_ready = 1'b1;

  firq29_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_action (in_action),
    .in_ready  (in_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  firq29_dp #(.MAX_TAPS(MAX_TAPS)) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .sts                 (sts),
    .in_coef_index       (in_coef_index),
    .in_data_value       (in_data_value),
    .cfg_we              (cfg_valid),
    .cfg_tap_count       (cfg_tap_count),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_filtered_sample (out_filtered_sample)
  );

endmodule

`default_nettype wire

>>> design/firq29_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none

module firq29_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 512
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> design/firq29_ctrl.sv
// Controller state machine that sequences loads, the tap walk and result delivery.
`default_nettype none

module firq29_ctrl
  import firq29_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  input  wire logic        in_action,
  output logic             in_ready,
  input  wire firq29_sts_t sts,
  output firq29_cmd_t      cmd
);

  firq29_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_action == ACTION_LOAD) begin
            cmd.accept_load = 1'b1;
          end else begin
            cmd.accept_sample = 1'b1;
            state_nxt         = ST_RUN;
          end
        end
      end
      ST_RUN: begin
        cmd.issue = 1'b1;
        if (sts.last_tap) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // The accumulator is complete once the read and multiply stages are empty.
        if (!sts.pipe_busy) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

`ifndef NO_ASSERTIONS
  a_finish_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> sts.out_free)
    else $error("result captured while the output register is still occupied");

  a_last_tap_ends_walk: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN && sts.last_tap) |=> (state_r == ST_DRAIN))
    else $error("tap walk did not stop after the last tap");

  a_sample_starts_walk: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accept_sample |=> (state_r == ST_RUN))
    else $error("accepted sample did not start the tap walk");
`endif

endmodule

`default_nettype wire

>>> design/firq29_dp.sv
// Datapath: coefficient and history stores, address walk, multiply-accumulate and output register.
`default_nettype none

module firq29_dp
  import firq29_pkg::*;
#(
  parameter int MAX_TAPS = 512
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire firq29_cmd_t                 cmd,
  output firq29_sts_t                      sts,
  input  wire logic [COEF_IDX_W-1:0]       in_coef_index,
  input  wire logic signed [DATA_W-1:0]    in_data_value,
  input  wire logic                        cfg_we,
  input  wire logic [TAP_CFG_W-1:0]        cfg_tap_count,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic signed [DATA_W-1:0]         out_filtered_sample
);

  localparam int PTR_W = $clog2(MAX_TAPS);
  localparam int CNT_W = $clog2(MAX_TAPS + 1);
  localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(MAX_TAPS - 1);
  localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(MAX_TAPS);

  logic [PTR_W-1:0]         ptr_r, ptr_nxt;
  logic [CNT_W-1:0]         fill_r, fill_nxt;
  logic [CNT_W-1:0]         taps_r, taps_nxt;
  logic [PTR_W-1:0]         k_r, k_nxt;
  logic [PTR_W-1:0]         slot_r, slot_nxt;
  logic                     s1_valid_r, s1_zero_r;
  logic                     s2_valid_r;
  logic signed [ACC_W-1:0]  prod_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic                     out_valid_r;
  logic signed [DATA_W-1:0] out_data_r;
  logic [DATA_W-1:0]        coef_q, hist_q;
  logic                     coef_we;
  logic [PTR_W-1:0]         ptr_inc;

  assign ptr_inc = (ptr_r == LAST_SLOT) ? '0 : ptr_r + 1'b1;
  assign coef_we = cmd.accept_load && (32'(in_coef_index) < 32'(MAX_TAPS));

  firq29_ram #(.WIDTH(DATA_W), .DEPTH(MAX_TAPS)) u_coef_ram (
    .clk   (clk),
    .we    (coef_we),
    .waddr (PTR_W'(in_coef_index)),
    .wdata (in_data_value),
    .re    (cmd.issue),
    .raddr (k_r),
    .rdata (coef_q)
  );

  firq29_ram #(.WIDTH(DATA_W), .DEPTH(MAX_TAPS)) u_hist_ram (
    .clk   (clk),
    .we    (cmd.accept_sample),
    .waddr (ptr_inc),
    .wdata (in_data_value),
    .re    (cmd.issue),
    .raddr (slot_r),
    .rdata (hist_q)
  );

  always_comb begin
    ptr_nxt  = ptr_r;
    fill_nxt = fill_r;
    taps_nxt = taps_r;
    k_nxt    = k_r;
    slot_nxt = slot_r;
    if (cfg_we) begin
      if (cfg_tap_count == '0) begin
        taps_nxt = CNT_W'(1);
      end else if (32'(cfg_tap_count) > 32'(MAX_TAPS)) begin
        taps_nxt = FULL_CNT;
      end else begin
        taps_nxt = CNT_W'(cfg_tap_count);
      end
    end
    if (cmd.accept_sample) begin
      ptr_nxt  = ptr_inc;
      slot_nxt = ptr_inc;
      k_nxt    = '0;
      // The history store is never cleared: slots older than the fill count read as zero.
      if (fill_r != FULL_CNT) begin
        fill_nxt = fill_r + 1'b1;
      end
    end else if (cmd.issue) begin
      k_nxt    = k_r + 1'b1;
      slot_nxt = (slot_r == '0) ? LAST_SLOT : slot_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r       <= '0;
      fill_r      <= '0;
      taps_r      <= FULL_CNT;
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      ptr_r      <= ptr_nxt;
      fill_r     <= fill_nxt;
      taps_r     <= taps_nxt;
      s1_valid_r <= cmd.issue;
      s2_valid_r <= s1_valid_r;
      if (cmd.finish) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    k_r       <= k_nxt;
    slot_r    <= slot_nxt;
    s1_zero_r <= CNT_W'(k_r) >= fill_r;
    if (s1_zero_r) begin
      prod_r <= '0;
    end else begin
      prod_r <= $signed(coef_q) * $signed(hist_q);
    end
    if (cmd.accept_sample) begin
      acc_r <= '0;
    end else if (s2_valid_r) begin
      acc_r <= acc_r + prod_r;
    end
    if (cmd.finish) begin
      out_data_r <= acc_r[OUT_SHIFT +: DATA_W];
    end
  end

  assign sts.last_tap        = (CNT_W'(k_r) == taps_r - 1'b1);
  assign sts.pipe_busy       = s1_valid_r || s2_valid_r;
  assign sts.out_free        = !out_valid_r || out_ready;
  assign out_valid           = out_valid_r;
  assign out_filtered_sample = out_data_r;

`ifndef NO_ASSERTIONS
  a_fill_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FULL_CNT)
    else $error("history fill count ran past the store depth");

  a_finish_on_empty_pipe: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> (!s1_valid_r && !s2_valid_r))
    else $error("result taken before the last product was accumulated");

  a_taps_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (taps_r != '0) && (taps_r <= FULL_CNT))
    else $error("effective tap count out of range");
`endif

endmodule

`default_nettype wire
